/* rtl/core/pcms_pkg.sv */
// pcms_pkg: shared constants and types for the pixel cds marker strip block
// no dependencies; used by every module under rtl/core
package pcms_pkg;

  // design constants
  localparam int MAX_MARKERS   = 8;
  localparam int MAX_ROW_WIDTH = 512;
  localparam int SAMPLE_BITS   = 16;

  // fixed field widths
  localparam int COORD_W  = 9;
  localparam int SAMPLE_W = 16;
  localparam int RWIDTH_W = 10;
  localparam int MCOUNT_W = 4;
  localparam int MREG_W   = 36;
  localparam int SLOT_W   = $clog2(MAX_MARKERS + 1);
  localparam int BELOW_W  = $clog2(MAX_MARKERS + 1);

  // stream word widths, padded to whole bytes
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 88;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MREG_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY_NEG = 3'd0,
    CFG_THREE_FRAME  = 3'd1,
    CFG_STRIP        = 3'd2,
    CFG_ROW_WIDTH    = 3'd3,
    CFG_MARKER_COUNT = 3'd4,
    CFG_MARKERS_LOW  = 3'd5,
    CFG_MARKERS_HIGH = 3'd6
  } cfg_idx_t;

  // reset values of the registers
  localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RST    = 10'd264;
  localparam logic [MCOUNT_W-1:0] MARKER_COUNT_RST = 4'd8;

  // marker setup seen by the column stripper
  typedef struct packed {
    logic                            strip;
    logic [MCOUNT_W-1:0]             count;
    logic [7:0][COORD_W-1:0]         slots;
  } strip_cfg_t;

  // stripper result
  typedef struct packed {
    logic               drop;
    logic [COORD_W-1:0] column;
  } strip_res_t;

endpackage

/* rtl/core/pcms_pos.sv */
// pcms_pos: raw pixel column and row tracking in scan order
// depends on pcms_pkg
module pcms_pos (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,      // raw word accepted
  input  logic                         frame_start,
  input  logic [pcms_pkg::RWIDTH_W-1:0] row_width,
  output logic [pcms_pkg::COORD_W-1:0] cur_column,
  output logic [pcms_pkg::COORD_W-1:0] cur_row
);

  logic [pcms_pkg::COORD_W-1:0]  col_r, col_nxt;
  logic [pcms_pkg::COORD_W-1:0]  row_r, row_nxt;
  logic [pcms_pkg::RWIDTH_W-1:0] next_col;
  logic                          wrap;

  // frame start restarts the scan at the origin
  always_comb begin
    cur_column = frame_start ? '0 : col_r;
    cur_row    = frame_start ? '0 : row_r;
  end

  // column increments and wraps into the next row
  always_comb begin
    next_col = {1'b0, cur_column} + pcms_pkg::RWIDTH_W'(1);
    wrap     = (next_col >= row_width) ||
               (next_col >= pcms_pkg::RWIDTH_W'(pcms_pkg::MAX_ROW_WIDTH));
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (advance) begin
      if (wrap) begin
        col_nxt = '0;
        row_nxt = cur_row + pcms_pkg::COORD_W'(1);
      end else begin
        col_nxt = next_col[pcms_pkg::COORD_W-1:0];
        row_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* rtl/core/pcms_strip.sv */
// pcms_strip: marker column compare and column remap, eight parallel slots
// depends on pcms_pkg
module pcms_strip (
  input  pcms_pkg::strip_cfg_t          cfg,
  input  logic [pcms_pkg::COORD_W-1:0]  column,
  output pcms_pkg::strip_res_t          res
);

  logic [pcms_pkg::SLOT_W-1:0]   used;
  logic [pcms_pkg::MAX_MARKERS-1:0] hit;
  logic [pcms_pkg::MAX_MARKERS-1:0] below;
  logic [pcms_pkg::BELOW_W-1:0]  below_cnt;

  // slots in use saturate at the slot count
  always_comb begin
    if (cfg.count > pcms_pkg::MCOUNT_W'(pcms_pkg::MAX_MARKERS)) begin
      used = pcms_pkg::SLOT_W'(pcms_pkg::MAX_MARKERS);
    end else begin
      used = pcms_pkg::SLOT_W'(cfg.count);
    end
  end

  // per-slot compares and count of markers below the column
  always_comb begin
    below_cnt = '0;
    for (int i = 0; i < pcms_pkg::MAX_MARKERS; i++) begin
      hit[i]   = (pcms_pkg::SLOT_W'(i) < used) && (cfg.slots[i] == column);
      below[i] = (pcms_pkg::SLOT_W'(i) < used) && (cfg.slots[i] < column);
      below_cnt = below_cnt + pcms_pkg::BELOW_W'(below[i]);
    end
  end

  always_comb begin
    if (cfg.strip) begin
      res.drop   = |hit;
      res.column = column - pcms_pkg::COORD_W'(below_cnt);
    end else begin
      res.drop   = 1'b0;
      res.column = column;
    end
  end

endmodule

/* rtl/core/pcms_cds.sv */
// pcms_cds: correlated double sample with frame pair selection and polarity
// depends on pcms_pkg
module pcms_cds (
  input  logic                                polarity_neg,
  input  logic                                three_frame,
  input  logic                                pivot_passed,
  input  logic signed [pcms_pkg::SAMPLE_W-1:0] sample_one,
  input  logic signed [pcms_pkg::SAMPLE_W-1:0] sample_two,
  input  logic signed [pcms_pkg::SAMPLE_W-1:0] sample_three,
  output logic signed [pcms_pkg::SAMPLE_W-1:0] double_sample
);

  logic signed [pcms_pkg::SAMPLE_W:0] minuend;
  logic signed [pcms_pkg::SAMPLE_W:0] subtrahend;
  logic signed [pcms_pkg::SAMPLE_W:0] diff;
  logic signed [pcms_pkg::SAMPLE_W:0] signed_diff;

  // pick frame pair, subtract, apply polarity, wrap to sample width
  always_comb begin
    if (three_frame && !pivot_passed) begin
      minuend    = (pcms_pkg::SAMPLE_W+1)'(sample_three);
      subtrahend = (pcms_pkg::SAMPLE_W+1)'(sample_two);
    end else begin
      minuend    = (pcms_pkg::SAMPLE_W+1)'(sample_two);
      subtrahend = (pcms_pkg::SAMPLE_W+1)'(sample_one);
    end
    diff          = minuend - subtrahend;
    signed_diff   = polarity_neg ? -diff : diff;
    double_sample = pcms_pkg::SAMPLE_W'($signed(signed_diff[pcms_pkg::SAMPLE_BITS-1:0]));
  end

endmodule

/* rtl/core/pixel_cds_marker_strip_top.sv */
// pixel_cds_marker_strip_top: pixel readout with double sampling and marker strip
// depends on pcms_pkg, pcms_pos, pcms_strip, pcms_cds
// an accepted input word's result is registered and shows on out_ in the next cycle
// one word per cycle while out_tready is high; the single output register frees as taken
// marker words are dropped in the same cycle, so no result appears for them
// reset (rst_n low, synchronous) clears counters, output valid and config to defaults
module pixel_cds_marker_strip_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // frame_start[0], sample_one[16:1], sample_two[32:17], sample_three[48:33],
  // pivot_passed[49], sparse_column[58:50], sparse_row[67:59], zero pad
  input  logic [pcms_pkg::IN_DATA_W-1:0]   in_tdata,
  // func[0]
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_column[8:0], out_row[17:9], out_sample_one[33:18],
  // out_sample_two[49:34], out_sample_three[65:50], double_sample[81:66], zero pad
  output logic [pcms_pkg::OUT_DATA_W-1:0]  out_tdata,
  // from_sparse[0]
  output logic                             out_tuser,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcms_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = pcms_pkg::COORD_W;
  localparam int SW = pcms_pkg::SAMPLE_W;

  // configuration registers
  logic                          polarity_neg_r;
  logic                          three_frame_r;
  logic                          strip_r;
  logic [pcms_pkg::RWIDTH_W-1:0] row_width_r;
  logic [pcms_pkg::MCOUNT_W-1:0] marker_count_r;
  logic [pcms_pkg::MREG_W-1:0]   markers_low_r;
  logic [pcms_pkg::MREG_W-1:0]   markers_high_r;

  // input word fields
  logic                 func;
  logic                 frame_start;
  logic signed [SW-1:0] sample_one;
  logic signed [SW-1:0] sample_two;
  logic signed [SW-1:0] sample_three;
  logic                 pivot_passed;
  logic [CW-1:0]        sparse_column;
  logic [CW-1:0]        sparse_row;

  logic                 in_acc;
  logic [CW-1:0]        raw_column;
  logic [CW-1:0]        raw_row;
  logic [CW-1:0]        pix_column;
  pcms_pkg::strip_cfg_t strip_cfg;
  pcms_pkg::strip_res_t strip_res;
  logic signed [SW-1:0] ds;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 from_sparse_r;
  logic [CW-1:0]        column_r;
  logic [CW-1:0]        row_r;
  logic [SW-1:0]        s1_r;
  logic [SW-1:0]        s2_r;
  logic [SW-1:0]        s3_r;
  logic [SW-1:0]        ds_r;

  // unpack input word
  always_comb begin
    func          = in_tuser;
    frame_start   = in_tdata[0];
    sample_one    = in_tdata[16:1];
    sample_two    = in_tdata[32:17];
    sample_three  = in_tdata[48:33];
    pivot_passed  = in_tdata[49];
    sparse_column = in_tdata[58:50];
    sparse_row    = in_tdata[67:59];
  end

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_neg_r <= 1'b1;
      three_frame_r  <= 1'b1;
      strip_r        <= 1'b0;
      row_width_r    <= pcms_pkg::ROW_WIDTH_RST;
      marker_count_r <= pcms_pkg::MARKER_COUNT_RST;
      markers_low_r  <= '0;
      markers_high_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcms_pkg::CFG_POLARITY_NEG: polarity_neg_r <= cfg_data[0];
        pcms_pkg::CFG_THREE_FRAME:  three_frame_r  <= cfg_data[0];
        pcms_pkg::CFG_STRIP:        strip_r        <= cfg_data[0];
        pcms_pkg::CFG_ROW_WIDTH:    row_width_r    <= cfg_data[pcms_pkg::RWIDTH_W-1:0];
        pcms_pkg::CFG_MARKER_COUNT: marker_count_r <= cfg_data[pcms_pkg::MCOUNT_W-1:0];
        pcms_pkg::CFG_MARKERS_LOW:  markers_low_r  <= cfg_data;
        pcms_pkg::CFG_MARKERS_HIGH: markers_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan position of raw pixels
  pcms_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_acc && !func),
    .frame_start (frame_start),
    .row_width   (row_width_r),
    .cur_column  (raw_column),
    .cur_row     (raw_row)
  );

  // marker slot layout
  always_comb begin
    strip_cfg.strip = strip_r;
    strip_cfg.count = marker_count_r;
    for (int i = 0; i < 4; i++) begin
      strip_cfg.slots[i]   = markers_low_r[i*CW +: CW];
      strip_cfg.slots[i+4] = markers_high_r[i*CW +: CW];
    end
  end

  assign pix_column = func ? sparse_column : raw_column;

  pcms_strip u_strip (
    .cfg    (strip_cfg),
    .column (pix_column),
    .res    (strip_res)
  );

  pcms_cds u_cds (
    .polarity_neg  (polarity_neg_r),
    .three_frame   (three_frame_r),
    .pivot_passed  (pivot_passed),
    .sample_one    (sample_one),
    .sample_two    (sample_two),
    .sample_three  (sample_three),
    .double_sample (ds)
  );

  // output valid control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      out_valid_nxt = in_acc && !strip_res.drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc && !strip_res.drop) begin
      from_sparse_r <= func;
      column_r      <= strip_res.column;
      s1_r          <= sample_one;
      if (func) begin
        row_r <= sparse_row;
        s2_r  <= '0;
        s3_r  <= '0;
        ds_r  <= '0;
      end else begin
        row_r <= raw_row;
        s2_r  <= sample_two;
        s3_r  <= three_frame_r ? sample_three : '0;
        ds_r  <= ds;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = from_sparse_r;
  assign out_tdata  = {6'd0, ds_r, s3_r, s2_r, s1_r, row_r, column_r};

endmodule

/* tb/tb_pixel_cds_marker_strip_top.sv */
// testbench for pixel_cds_marker_strip_top: directed and random pixel streams,
// random idling on both stream sides and a self-checking prediction of every result word
// depends on pcms_pkg and the rtl under rtl/core
module tb_pixel_cds_marker_strip_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcms_pkg::*;

  localparam logic PIXEL_RAW    = 1'b0;
  localparam logic PIXEL_SPARSE = 1'b1;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   LONG_HOLD    = 300;
  localparam int   SETTLE_WAIT  = 4;

  // one input word, unpacked
  typedef struct packed {
    logic                func;
    logic                frame_start;
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
    logic [SAMPLE_W-1:0] sample_three;
    logic                pivot_passed;
    logic [COORD_W-1:0]  sparse_column;
    logic [COORD_W-1:0]  sparse_row;
  } pixel_t;

  // one result word, unpacked
  typedef struct packed {
    logic                from_sparse;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
    logic [SAMPLE_W-1:0] sample_three;
    logic [SAMPLE_W-1:0] double_sample;
  } readout_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register shadow copies
  logic                polarity_neg;
  logic                three_frame;
  logic                strip_on;
  logic [RWIDTH_W-1:0] row_width;
  logic [MCOUNT_W-1:0] mk_count;
  logic [MREG_W-1:0]   mk_low;
  logic [MREG_W-1:0]   mk_high;

  // scan position of the next raw pixel
  logic [COORD_W-1:0] raw_col;
  logic [COORD_W-1:0] raw_row;

  pixel_t   pixel_queue[$];
  readout_t expected_readouts[$];
  pixel_t   offered_pixel;
  int       pixels_in_flight = 0;
  int       fail_count = 0;
  int       cycle_count = 0;
  int       in_gap_max = 16;
  int       out_gap_max = 16;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_left = 0;
  bit       hold_request = 1'b0;
  bit       word_taken = 1'b0;

  pixel_cds_marker_strip_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // gap before the next word, zero about a third of the time
  function automatic int draw_gap(input int gap_max);
    if (gap_max == 0 || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, gap_max);
  endfunction

  function automatic logic [COORD_W-1:0] marker_slot(input int i);
    if (i < 4) return mk_low[9*i +: 9];
    return mk_high[9*(i-4) +: 9];
  endfunction

  // marker hit check and left shift of the column
  function automatic logic strip_column(input logic [COORD_W-1:0] col,
                                        output logic [COORD_W-1:0] mapped);
    int used;
    int below;
    logic [COORD_W-1:0] slot;
    used = (mk_count > MAX_MARKERS) ? MAX_MARKERS : int'(mk_count);
    below = 0;
    mapped = col;
    if (!strip_on) return 1'b0;
    for (int i = 0; i < used; i++) begin
      slot = marker_slot(i);
      if (slot == col) return 1'b1;
      if (slot < col) below++;
    end
    mapped = col - below[COORD_W-1:0];
    return 1'b0;
  endfunction

  // expected result of one accepted pixel, queued unless it is stripped
  function automatic void predict_readout(input pixel_t px);
    readout_t r;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] mapped;
    logic drop;
    int diff;
    int nxt;
    r = '0;
    if (px.func == PIXEL_SPARSE) begin
      drop = strip_column(px.sparse_column, mapped);
      r.from_sparse = 1'b1;
      r.column = mapped;
      r.row = px.sparse_row;
      r.sample_one = px.sample_one;
    end else begin
      if (px.frame_start) begin
        raw_col = '0;
        raw_row = '0;
      end
      col = raw_col;
      row = raw_row;
      if (three_frame && !px.pivot_passed)
        diff = int'($signed(px.sample_three)) - int'($signed(px.sample_two));
      else
        diff = int'($signed(px.sample_two)) - int'($signed(px.sample_one));
      if (polarity_neg) diff = -diff;
      // column wraps at the row width or the widest row
      nxt = int'(col) + 1;
      if (nxt >= int'(row_width) || nxt >= MAX_ROW_WIDTH) begin
        raw_col = '0;
        raw_row = row + 9'd1;
      end else begin
        raw_col = nxt[COORD_W-1:0];
      end
      drop = strip_column(col, mapped);
      r.from_sparse = 1'b0;
      r.column = mapped;
      r.row = row;
      r.sample_one = px.sample_one;
      r.sample_two = px.sample_two;
      r.sample_three = three_frame ? px.sample_three : '0;
      r.double_sample = diff[SAMPLE_W-1:0];
    end
    if (!drop) expected_readouts.insert(expected_readouts.size(), r);
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // input driver, new word on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else if (in_tvalid && !word_taken) begin
      // word still waiting for ready
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap--;
    end else if (pixel_queue.size() > 0) begin
      offered_pixel = pixel_queue.pop_front();
      in_tdata <= {4'b0, offered_pixel.sparse_row, offered_pixel.sparse_column,
                   offered_pixel.pivot_passed, offered_pixel.sample_three,
                   offered_pixel.sample_two, offered_pixel.sample_one,
                   offered_pixel.frame_start};
      in_tuser <= offered_pixel.func;
      in_tvalid <= 1'b1;
      send_gap = draw_gap(in_gap_max);
    end else begin
      in_tvalid <= 1'b0;
    end
    word_taken = 1'b0;
  end

  // result receiver ready, with random stalls and the long hold
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: check result words, predict accepted input words
  always @(posedge clk) begin
    readout_t got;
    readout_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.from_sparse   = out_tuser;
        got.column        = out_tdata[8:0];
        got.row           = out_tdata[17:9];
        got.sample_one    = out_tdata[33:18];
        got.sample_two    = out_tdata[49:34];
        got.sample_three  = out_tdata[65:50];
        got.double_sample = out_tdata[81:66];
        recv_gap = draw_gap(out_gap_max);
        if (expected_readouts.size() == 0) begin
          $error("result word with no expected result: column %0d row %0d",
                 got.column, got.row);
          fail_count++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("from_sparse", int'(want.from_sparse), int'(got.from_sparse));
          check_field("out_column", int'(want.column), int'(got.column));
          check_field("out_row", int'(want.row), int'(got.row));
          check_field("out_sample_one", int'($signed(want.sample_one)),
                      int'($signed(got.sample_one)));
          check_field("out_sample_two", int'($signed(want.sample_two)),
                      int'($signed(got.sample_two)));
          check_field("out_sample_three", int'($signed(want.sample_three)),
                      int'($signed(got.sample_three)));
          check_field("double_sample", int'($signed(want.double_sample)),
                      int'($signed(got.double_sample)));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_readout(offered_pixel);
        pixels_in_flight--;
        word_taken = 1'b1;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POLARITY_NEG: polarity_neg = value[0];
      CFG_THREE_FRAME:  three_frame  = value[0];
      CFG_STRIP:        strip_on     = value[0];
      CFG_ROW_WIDTH:    row_width    = value[RWIDTH_W-1:0];
      CFG_MARKER_COUNT: mk_count     = value[MCOUNT_W-1:0];
      CFG_MARKERS_LOW:  mk_low       = value;
      CFG_MARKERS_HIGH: mk_high      = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every word is taken and every result has come
  task automatic wait_idle();
    while (pixels_in_flight != 0 || expected_readouts.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  function automatic pixel_t px(input logic func, input logic fs, input logic [15:0] s1,
                                input logic [15:0] s2, input logic [15:0] s3,
                                input logic piv, input logic [8:0] col,
                                input logic [8:0] row);
    pixel_t p;
    p.func = func;
    p.frame_start = fs;
    p.sample_one = s1;
    p.sample_two = s2;
    p.sample_three = s3;
    p.pivot_passed = piv;
    p.sparse_column = col;
    p.sparse_row = row;
    return p;
  endfunction

  function automatic void queue_pixel(input pixel_t p);
    pixel_queue.insert(pixel_queue.size(), p);
    pixels_in_flight++;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // sparse column near a marker, at an edge or anywhere
  function automatic logic [8:0] pick_column();
    logic [8:0] c;
    c = marker_slot($urandom_range(0, 7));
    case ($urandom_range(0, 4))
      0: c = c + 9'd1;
      1: c = c - 9'd1;
      2: c = 9'($urandom_range(0, 511));
      3: c = $urandom_range(0, 1) ? 9'd511 : 9'd0;
      default: ;
    endcase
    return c;
  endfunction

  function automatic pixel_t rand_raw(input logic fs);
    return px(PIXEL_RAW, fs, rand_sample(), rand_sample(), rand_sample(),
              1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
              9'($urandom_range(0, 511)));
  endfunction

  function automatic pixel_t rand_sparse();
    return px(PIXEL_SPARSE, 1'($urandom_range(0, 1)), rand_sample(), rand_sample(),
              rand_sample(), 1'($urandom_range(0, 1)), pick_column(),
              9'($urandom_range(0, 511)));
  endfunction

  // one frame in scan order with stray sparse pixels and rare broken restarts
  function automatic void queue_frame(input int n);
    int k;
    queue_pixel(rand_raw(1'b1));
    for (int i = 1; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0) queue_pixel(rand_raw(1'b1));
      else if (k < 4) queue_pixel(rand_sparse());
      else queue_pixel(rand_raw(1'b0));
    end
  endfunction

  function automatic logic [MREG_W-1:0] rand_markers(input int width);
    logic [MREG_W-1:0] m;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 3) != 0 && width > 0)
        m[9*i +: 9] = 9'($urandom_range(0, width - 1));
      else
        m[9*i +: 9] = 9'($urandom_range(0, 511));
    end
    return m;
  endfunction

  task automatic random_setup(input int width);
    logic [MCOUNT_W-1:0] cnt;
    case ($urandom_range(0, 5))
      0: cnt = 4'd0;
      1: cnt = 4'($urandom_range(9, 15));
      default: cnt = 4'($urandom_range(1, 8));
    endcase
    write_reg(CFG_POLARITY_NEG, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(CFG_THREE_FRAME, CFG_DATA_W'($urandom_range(0, 1)));
    write_reg(CFG_STRIP, CFG_DATA_W'($urandom_range(0, 3) != 0));
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_MARKER_COUNT, CFG_DATA_W'(cnt));
    write_reg(CFG_MARKERS_LOW, rand_markers(width));
    write_reg(CFG_MARKERS_HIGH, rand_markers(width));
  endtask

  // stimulus and phase sequencing
  initial begin
    int width;
    polarity_neg = 1'b1;
    three_frame  = 1'b1;
    strip_on     = 1'b0;
    row_width    = ROW_WIDTH_RST;
    mk_count     = MARKER_COUNT_RST;
    mk_low       = '0;
    mk_high      = '0;
    raw_col      = '0;
    raw_row      = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: sample extremes, both frame pairs, sparse edges, restart
    queue_pixel(px(PIXEL_RAW, 1'b1, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, 9'd0, 9'd0));
    queue_pixel(px(PIXEL_RAW, 1'b0, 16'h8000, 16'h7fff, 16'h8000, 1'b0, 9'd511, 9'd511));
    queue_pixel(px(PIXEL_RAW, 1'b0, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 9'd0, 9'd511));
    queue_pixel(px(PIXEL_RAW, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 9'd511, 9'd0));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'h8000, 16'h1234, 16'h4321, 1'b1, 9'd0, 9'd0));
    queue_pixel(px(PIXEL_SPARSE, 1'b1, 16'h7fff, 16'hffff, 16'hffff, 1'b0, 9'd511, 9'd511));
    queue_pixel(px(PIXEL_RAW, 1'b1, 16'hffff, 16'h0001, 16'hffff, 1'b1, 9'd0, 9'd0));
    wait_idle();

    // two-frame, positive polarity, markers at 0 and a duplicated 3
    write_reg(CFG_POLARITY_NEG, CFG_DATA_W'(0));
    write_reg(CFG_THREE_FRAME, CFG_DATA_W'(0));
    write_reg(CFG_STRIP, CFG_DATA_W'(1));
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(6));
    write_reg(CFG_MARKER_COUNT, CFG_DATA_W'(3));
    write_reg(CFG_MARKERS_LOW, {9'd9, 9'd3, 9'd3, 9'd0});
    queue_pixel(rand_raw(1'b1));
    repeat (11) queue_pixel(rand_raw(1'b0));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'h5a5a, 16'h0, 16'h0, 1'b0, 9'd3, 9'd7));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'ha5a5, 16'h0, 16'h0, 1'b0, 9'd10, 9'd5));
    wait_idle();

    // stripping on with no slots in use, zero row width acts as one
    write_reg(CFG_MARKER_COUNT, CFG_DATA_W'(0));
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(0));
    queue_pixel(rand_raw(1'b1));
    queue_pixel(rand_raw(1'b0));
    queue_pixel(rand_raw(1'b0));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'h0001, 16'h0, 16'h0, 1'b1, 9'd3, 9'd1));
    wait_idle();

    // saturated slot count, all-ones low markers, widest row
    write_reg(CFG_MARKER_COUNT, CFG_DATA_W'(15));
    write_reg(CFG_MARKERS_LOW, 36'hf_ffff_ffff);
    write_reg(CFG_MARKERS_HIGH, {9'd5, 9'd200, 9'd100, 9'd511});
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(512));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'h7fff, 16'h0, 16'h0, 1'b0, 9'd511, 9'd2));
    queue_pixel(px(PIXEL_SPARSE, 1'b0, 16'h8000, 16'h0, 16'h0, 1'b0, 9'd300, 9'd3));
    queue_pixel(rand_raw(1'b1));
    wait_idle();

    // random settings and frames, first phase without idling
    for (int p = 0; p < 6; p++) begin
      width = (p == 2) ? 264 : $urandom_range(1, 24);
      in_gap_max  = (p == 0) ? 0 : 16;
      out_gap_max = (p == 0) ? 0 : 16;
      random_setup(width);
      queue_frame($urandom_range(6, 12));
      wait_idle();
    end

    // full-width row past the last column into the next row, receiver held off meanwhile
    in_gap_max  = 0;
    out_gap_max = 3;
    random_setup(512);
    queue_pixel(rand_raw(1'b1));
    repeat (513) queue_pixel(rand_raw(1'b0));
    hold_request = 1'b1;
    wait_idle();

    // one-column rows, every raw pixel starts a new row
    out_gap_max = 1;
    random_setup(1);
    queue_pixel(rand_raw(1'b1));
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(0, 9) == 0) queue_pixel(rand_sparse());
      else queue_pixel(rand_raw(1'b0));
    end
    wait_idle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
